// ===== hw/rtl/dcc_track_signal_generator_defines.svh =====
// Assertion macros for the DCC track signal generator.
// Depends on nothing; included by the files that carry assertions.
// Each macro samples at the rising edge of aclk and is disabled while aresetn is low.
`ifndef DCC_TRACK_SIGNAL_GENERATOR_DEFINES_SVH
`define DCC_TRACK_SIGNAL_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define DCC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
`define DCC_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);
`define DCC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define DCC_ASSERT_ALWAYS(label, expr, msg)
`define DCC_ASSERT_IMPL(label, pre, post, msg)
`define DCC_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== hw/rtl/dcc_tsg_pkg.sv =====
// Package for the DCC track signal generator: frame and symbol constants.
// No dependencies.
package dcc_tsg_pkg;

    localparam int unsigned FRAME_W = 64;
    localparam int unsigned SYM_W   = 8;
    localparam int unsigned ADDR_W  = 7;
    localparam int unsigned SPEED_W = 5;

    localparam logic [FRAME_W-1:0] IDLE_FRAME = 64'hFFFD_FE00_7FC0_0000;
    localparam logic [FRAME_W-1:0] FRAME_BASE = 64'hFFFC_0040_0040_0000;

    localparam logic [SYM_W-1:0] SYM_ONE  = 8'hFD;
    localparam logic [SYM_W-1:0] SYM_ZERO = 8'hF3;
    localparam logic [SYM_W-1:0] SYM_FILL = 8'h80;
    localparam logic [SYM_W-1:0] SYM_DONE = 8'hFF;

    localparam logic [1:0] CTRL_PREFIX = 2'b01;

    // Bit positions of the fields within the frame
    localparam int unsigned ADDR_LSB = 41;
    localparam int unsigned CTRL_LSB = 32;
    localparam int unsigned XOR_LSB  = 23;

endpackage

// ===== hw/rtl/dcc_tsg_frame_build.sv =====
// Builds the 64-bit DCC packet frame from address, direction and speed code.
// Depends on dcc_tsg_pkg.
module dcc_tsg_frame_build import dcc_tsg_pkg::*; (
    input  logic [ADDR_W-1:0]  loco_address,
    input  logic               direction,
    input  logic [SPEED_W-1:0] speed_code,
    output logic [FRAME_W-1:0] frame
);

    logic [7:0] addr_byte;
    logic [7:0] ctrl_byte;
    logic [7:0] check_byte;

    always_comb begin
        addr_byte  = {1'b0, loco_address};
        ctrl_byte  = {CTRL_PREFIX, direction, speed_code};
        check_byte = addr_byte ^ ctrl_byte;
        frame      = FRAME_BASE
                   | ({56'd0, addr_byte}  << ADDR_LSB)
                   | ({56'd0, ctrl_byte}  << CTRL_LSB)
                   | ({56'd0, check_byte} << XOR_LSB);
    end

endmodule

// ===== hw/rtl/dcc_track_signal_generator.sv =====
// DCC track signal generator: a tick transfer (s_command = 0) yields one half-bit track
// level on the m_ channel in the next cycle; a load transfer (s_command = 1) builds a new
// packet frame, queues it as pending and yields nothing. One transfer is taken every clock
// while the result register is empty or being drained; the whole tick update (symbol
// shift, frame-empty test, frame select) sits between the input and the result register.
// A pending frame is sent once the current frame runs out of one bits and is then
// repeated; after reset the idle packet repeats. No clearing pass.
// Depends on dcc_tsg_pkg, dcc_tsg_frame_build and dcc_track_signal_generator_defines.svh.
`include "dcc_track_signal_generator_defines.svh"
module dcc_track_signal_generator import dcc_tsg_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [ADDR_W-1:0]  s_loco_address,
    input  logic               s_direction,
    input  logic [SPEED_W-1:0] s_speed_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_line_level
);

    logic [FRAME_W-1:0] shift_frame_reg, shift_frame_next;
    logic [FRAME_W-1:0] repeat_frame_reg, repeat_frame_next;
    logic [FRAME_W-1:0] pending_frame_reg, pending_frame_next;
    logic               pending_flag_reg, pending_flag_next;
    logic [SYM_W-1:0]   symbol_reg, symbol_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_line_level_reg, m_line_level_next;

    logic [FRAME_W-1:0] built_frame;
    logic [FRAME_W-1:0] cur_frame;
    logic [SYM_W-1:0]   cur_symbol;
    logic               accept;
    logic               tick;
    logic               load;

    dcc_tsg_frame_build u_frame_build (
        .loco_address (s_loco_address),
        .direction    (s_direction),
        .speed_code   (s_speed_code),
        .frame        (built_frame)
    );

    assign s_ready      = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_line_level = m_line_level_reg;

    assign accept = s_valid && s_ready;
    assign tick   = accept && !s_command;
    assign load   = accept && s_command;

    always_comb begin
        shift_frame_next   = shift_frame_reg;
        repeat_frame_next  = repeat_frame_reg;
        pending_frame_next = pending_frame_reg;
        pending_flag_next  = pending_flag_reg;
        symbol_next        = symbol_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_line_level_next  = m_line_level_reg;
        cur_frame          = shift_frame_reg;
        cur_symbol         = symbol_reg;

        if (load) begin
            pending_frame_next = built_frame;
            pending_flag_next  = 1'b1;
        end else if (tick) begin
            if (symbol_reg == SYM_DONE) begin
                if (shift_frame_reg == '0) begin
                    if (pending_flag_reg) begin
                        cur_frame         = pending_frame_reg;
                        repeat_frame_next = pending_frame_reg;
                        pending_flag_next = 1'b0;
                    end else begin
                        cur_frame = repeat_frame_reg;
                    end
                end
                cur_symbol       = cur_frame[FRAME_W-1] ? SYM_ONE : SYM_ZERO;
                shift_frame_next = {cur_frame[FRAME_W-2:0], 1'b0};
            end
            m_line_level_next = cur_symbol[0];
            symbol_next       = {1'b0, cur_symbol[SYM_W-1:1]} | SYM_FILL;
            m_valid_next      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_frame_reg   <= '0;
            repeat_frame_reg  <= IDLE_FRAME;
            pending_frame_reg <= '0;
            pending_flag_reg  <= 1'b0;
            symbol_reg        <= SYM_DONE;
            m_valid_reg       <= 1'b0;
        end else begin
            shift_frame_reg   <= shift_frame_next;
            repeat_frame_reg  <= repeat_frame_next;
            pending_frame_reg <= pending_frame_next;
            pending_flag_reg  <= pending_flag_next;
            symbol_reg        <= symbol_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_line_level_reg <= m_line_level_next;
    end

    `DCC_ASSERT_ALWAYS(a_sym_fill_top, symbol_reg[SYM_W-1], "symbol pattern lost its fill bit")
    `DCC_ASSERT_NEXT(a_tick_gives_level, tick, m_valid_reg, "tick transfer gave no level")
    `DCC_ASSERT_NEXT(a_load_pends, load, pending_flag_reg, "load transfer left nothing pending")
    `DCC_ASSERT_IMPL(a_take_sets_repeat, $fell(pending_flag_reg),
        repeat_frame_reg == pending_frame_reg, "taken frame not kept for repeat")
    `DCC_ASSERT_NEXT(a_load_no_level, load && !m_valid_reg, !m_valid_reg,
        "load transfer produced a level")

endmodule

// ===== sim/dcc_track_signal_generator_test.sv =====
`timescale 1ns / 1ps
// Testbench for dcc_track_signal_generator: directed rows then random ticks and loads,
// half-bit levels checked against a frame/symbol predictor held in the bench.
// Depends on dcc_tsg_pkg and the dcc_track_signal_generator RTL.
module dcc_track_signal_generator_test;
    import dcc_tsg_pkg::*;

    typedef enum logic { CMD_TICK = 1'b0, CMD_LOAD = 1'b1 } command_t;

    typedef struct {
        command_t           cmd;
        logic [ADDR_W-1:0]  addr;
        logic               dir;
        logic [SPEED_W-1:0] speed;
        bit                 known;
        logic               level;
    } track_item_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_command = 1'b0;
    logic [ADDR_W-1:0]  s_loco_address = '0;
    logic               s_direction = 1'b0;
    logic [SPEED_W-1:0] s_speed_code = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_line_level;

    // bench copy of the generator state
    logic [FRAME_W-1:0] tx_frame;
    logic [FRAME_W-1:0] resend_frame;
    logic [FRAME_W-1:0] queued_frame;
    bit                 queued_ok;
    logic [SYM_W-1:0]   half_bits;

    logic        level_q[$];
    int          mismatches = 0;
    bit          calm = 1'b0;
    int          stall_left = 0;
    logic        want_level;
    track_item_t directed_rows[18];

    dcc_track_signal_generator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_loco_address (s_loco_address),
        .s_direction    (s_direction),
        .s_speed_code   (s_speed_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_level   (m_line_level)
    );

    always #4 aclk = ~aclk;

    function automatic logic [FRAME_W-1:0] packet_frame(logic [ADDR_W-1:0] addr, logic dir,
                                                        logic [SPEED_W-1:0] speed);
        logic [7:0] addr_byte;
        logic [7:0] ctrl_byte;
        addr_byte = {1'b0, addr};
        ctrl_byte = {CTRL_PREFIX, dir, speed};
        return FRAME_BASE | (FRAME_W'(addr_byte) << ADDR_LSB)
                          | (FRAME_W'(ctrl_byte) << CTRL_LSB)
                          | (FRAME_W'(addr_byte ^ ctrl_byte) << XOR_LSB);
    endfunction

    task automatic track_step(input track_item_t it, output bit emits, output logic lvl);
        emits = 1'b0;
        lvl   = 1'b0;
        if (it.cmd == CMD_LOAD) begin
            queued_frame = packet_frame(it.addr, it.dir, it.speed);
            queued_ok    = 1'b1;
        end else begin
            if (half_bits == SYM_DONE) begin
                if (tx_frame == '0) begin
                    if (queued_ok) begin
                        tx_frame     = queued_frame;
                        resend_frame = queued_frame;
                        queued_ok    = 1'b0;
                    end else begin
                        tx_frame = resend_frame;
                    end
                end
                half_bits = tx_frame[FRAME_W-1] ? SYM_ONE : SYM_ZERO;
                tx_frame  = tx_frame << 1;
            end
            lvl       = half_bits[0];
            half_bits = (half_bits >> 1) | SYM_FILL;
            emits     = 1'b1;
        end
    endtask

    task automatic send_item(input track_item_t it);
        bit   emits;
        logic lvl;
        s_valid        <= 1'b1;
        s_command      <= it.cmd;
        s_loco_address <= it.addr;
        s_direction    <= it.dir;
        s_speed_code   <= it.speed;
        do @(posedge aclk); while (!s_ready);
        track_step(it, emits, lvl);
        if (emits) level_q.push_back(it.known ? it.level : lvl);
    endtask

    function automatic int gap_cycles();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic idle_gap();
        int g;
        g = gap_cycles();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 20) begin
            m_ready    <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (level_q.size() == 0) begin
                $error("line_level: expected nothing, actual %0b", m_line_level);
                mismatches++;
            end else begin
                want_level = level_q.pop_front();
                if (m_line_level !== want_level) begin
                    $error("line_level: expected %0b, actual %0b", want_level, m_line_level);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        track_item_t it;
        int          load_pct;
        int          burst;

        tx_frame     = '0;
        resend_frame = IDLE_FRAME;
        queued_frame = '0;
        queued_ok    = 1'b0;
        half_bits    = SYM_DONE;
        load_pct     = 2;
        burst        = 0;

        // idle packet leads with ones: levels 1,0 per bit; loads wait for the frame to end
        directed_rows = '{
            '{CMD_TICK, 7'd0,   1'b0, 5'd0,  1'b1, 1'b1},
            '{CMD_TICK, 7'd127, 1'b1, 5'd31, 1'b1, 1'b0},
            '{CMD_TICK, 7'd0,   1'b1, 5'd0,  1'b1, 1'b1},
            '{CMD_TICK, 7'd127, 1'b0, 5'd31, 1'b1, 1'b0},
            '{CMD_LOAD, 7'd0,   1'b0, 5'd0,  1'b0, 1'b0},
            '{CMD_TICK, 7'd85,  1'b1, 5'd10, 1'b1, 1'b1},
            '{CMD_TICK, 7'd42,  1'b0, 5'd21, 1'b1, 1'b0},
            '{CMD_LOAD, 7'd127, 1'b1, 5'd31, 1'b0, 1'b0},
            '{CMD_TICK, 7'd0,   1'b0, 5'd0,  1'b1, 1'b1},
            '{CMD_TICK, 7'd127, 1'b1, 5'd31, 1'b1, 1'b0},
            '{CMD_LOAD, 7'd85,  1'b0, 5'd21, 1'b0, 1'b0},
            '{CMD_LOAD, 7'd42,  1'b1, 5'd10, 1'b0, 1'b0},
            '{CMD_LOAD, 7'd127, 1'b0, 5'd0,  1'b0, 1'b0},
            '{CMD_LOAD, 7'd0,   1'b1, 5'd31, 1'b0, 1'b0},
            '{CMD_TICK, 7'd1,   1'b0, 5'd1,  1'b1, 1'b1},
            '{CMD_TICK, 7'd64,  1'b1, 5'd16, 1'b1, 1'b0},
            '{CMD_TICK, 7'd0,   1'b0, 5'd0,  1'b1, 1'b1},
            '{CMD_TICK, 7'd127, 1'b1, 5'd31, 1'b1, 1'b0}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i]);
            idle_gap();
        end

        for (int n = 0; n < 900; n++) begin
            if (n % 100 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0: load_pct = 0;
                    1: load_pct = 2;
                    default: load_pct = 8;
                endcase
            end
            if (n == 450) begin
                s_valid <= 1'b0;
                while (level_q.size() != 0) @(posedge aclk);
            end
            it.known = 1'b0;
            it.level = 1'b0;
            it.addr  = ADDR_W'($urandom_range(0, 127));
            it.dir   = 1'($urandom_range(0, 1));
            it.speed = SPEED_W'($urandom_range(0, 31));
            if (burst > 0) begin
                it.cmd = CMD_LOAD;
                burst--;
            end else if ($urandom_range(0, 99) < load_pct) begin
                it.cmd = CMD_LOAD;
                if ($urandom_range(0, 4) == 0) burst = $urandom_range(1, 3);
            end else begin
                it.cmd = CMD_TICK;
            end
            send_item(it);
            idle_gap();
        end

        s_valid <= 1'b0;
        while (level_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== dcc_track_signal_generator.f =====
+incdir+hw/rtl
hw/rtl/dcc_tsg_pkg.sv
hw/rtl/dcc_tsg_frame_build.sv
hw/rtl/dcc_track_signal_generator.sv
sim/dcc_track_signal_generator_test.sv
